@@ rtl/core/lcmr_pkg.sv @@
//------------------------------------------------------------------------------
// lcmr_pkg: shared types and constants of the Li Chao max tree
// Request and response layouts, request and status codes, sequencer states.
//------------------------------------------------------------------------------
package lcmr_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD     = 2'd0,
		REQ_INSERT   = 2'd1,
		REQ_QUERY    = 2'd2,
		REQ_ROLLBACK = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_EMPTY  = 2'd1,
		STS_BEYOND = 2'd2,
		STS_FULL   = 2'd3
	} status_t;

	// Intercept value of a node that holds no line.
	localparam logic signed [63:0] NEG_MARK = -64'sd5000000000000000000;

	typedef struct packed {
		logic        [1:0]  req_type;
		logic        [9:0]  coord_index;
		logic signed [31:0] coord_value;
		logic signed [31:0] slope;
		logic signed [31:0] intercept;
		logic        [31:0] version;
	} req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [63:0] best_value;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LB_RD,
		ST_LB_CMP,
		ST_QC_RD,
		ST_QC_CAP,
		ST_Q_RD,
		ST_Q_CAP,
		ST_I_RD,
		ST_I_CAP,
		ST_I_TM,
		ST_MUL,
		ST_ADD,
		ST_Q_UPD,
		ST_I_UPD,
		ST_RB_RD,
		ST_RB_CHK,
		ST_RESP
	} state_t;

endpackage

@@ rtl/core/li_chao_max_rollback.sv @@
//------------------------------------------------------------------------------
// li_chao_max_rollback: Li Chao tree for maximum with versioned undo
// Loads coordinates, inserts lines, queries the upper envelope, rolls back.
//------------------------------------------------------------------------------
// A load is answered directly; an insert walks the tree level by level; a
// query runs a lower-bound search and then walks the tree; a rollback pops
// and restores nodes one by one. One request at a time; all evaluations use
// the single shared multiply-add unit. After reset a clearing pass fills the
// node store before the first request is taken.
module li_chao_max_rollback #(
	parameter int MAX_COORDS = 1024,
	parameter int TREE_NODES = 4096,
	parameter int UNDO_DEPTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  lcmr_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output lcmr_pkg::rsp_t      rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [10:0]         cfg_data
);

	localparam int CW   = $clog2(MAX_COORDS);
	localparam int CNTW = $clog2(MAX_COORDS + 1);
	localparam int NW   = $clog2(TREE_NODES);
	localparam int UW   = $clog2(UNDO_DEPTH);
	localparam int CNT_RST = (MAX_COORDS < 1024) ? MAX_COORDS : 1024;

	// Nodes on the longest root-to-leaf path for a span of count minus one.
	function automatic logic [7:0] path_levels(input logic [31:0] cnt);
		logic [31:0] span;
		logic [7:0]  len;
		span = cnt - 32'd2;
		len = 8'd0;
		for (int i = 0; i < 32; i++) begin
			if (span[i]) begin
				len = 8'(i + 1);
			end
		end
		return len + 8'd1;
	endfunction

	localparam logic [7:0] LEVELS_RST = path_levels(32'(CNT_RST));

	lcmr_pkg::state_t state_q, state_d;

	lcmr_pkg::req_t      req_q;
	logic [1:0]          sts_q;
	logic signed [63:0]  m_q;
	logic [CNTW-1:0]     count_q;
	logic [7:0]          levels_q;
	logic [CNTW-1:0]     first_q, len_q;
	logic signed [31:0]  cx_q;
	logic [NW:0]         v_q;
	logic [CNTW-1:0]     tl_q, tr_q;
	logic signed [31:0]  ns_q, ls_q;
	logic signed [63:0]  nb_q, lb_q;
	logic signed [31:0]  ctl_q, ctm_q;
	logic signed [63:0]  p_q;
	logic signed [63:0]  e_q [4];
	logic [1:0]          k_q;
	logic [UW:0]         top_q;
	logic [NW-1:0]       clr_q;
	logic                rsp_valid_q;
	lcmr_pkg::rsp_t      rsp_q;

	// Memories and their registered read data.
	logic signed [31:0] coord_mem [MAX_COORDS];
	logic signed [31:0] nslope_mem [TREE_NODES];
	logic signed [63:0] nint_mem [TREE_NODES];
	logic [NW-1:0]      unode_mem [UNDO_DEPTH];
	logic [31:0]        uver_mem [UNDO_DEPTH];
	logic signed [31:0] uslope_mem [UNDO_DEPTH];
	logic signed [63:0] uint_mem [UNDO_DEPTH];

	logic signed [31:0] coord_rd, nslope_rd, uslope_rd;
	logic signed [63:0] nint_rd, uint_rd;
	logic [NW-1:0]      unode_rd;
	logic [31:0]        uver_rd;

	logic               coord_we, node_we, undo_we;
	logic [CW-1:0]      coord_wa, coord_ra;
	logic [NW-1:0]      node_wa, node_ra;
	logic signed [31:0] node_ws;
	logic signed [63:0] node_wb;
	logic [UW-1:0]      undo_wa, undo_ra;

	// Derived control values.
	logic                req_fire, cfg_fire;
	logic [CNTW-1:0]     half, lb_addr, n_w, tm_w;
	logic [CNTW:0]       tsum;
	logic                last_lvl;
	logic                undo_full;
	logic                go_left_q, go_left_i, mid_w, left_w;
	logic [NW:0]         v_next;
	logic signed [31:0]  mul_a, mul_c;
	logic signed [63:0]  mul_b;
	logic [31:0]         idx32, cfg_sat;
	logic [CNTW-1:0]     cfg_cnt;

	assign req_fire  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign half     = len_q >> 1;
	assign lb_addr  = first_q + half;
	assign n_w      = count_q - CNTW'(1);
	assign tsum     = (CNTW+1)'(tl_q) + (CNTW+1)'(tr_q);
	assign tm_w     = tsum[CNTW:1];
	assign last_lvl = ((CNTW+1)'(tl_q) + (CNTW+1)'(1)) >= (CNTW+1)'(tr_q);
	assign undo_full = (32'(UNDO_DEPTH) - 32'(top_q)) < 32'(levels_q);
	assign idx32    = 32'(req.coord_index);

	// A query descends toward the side that holds x; an insert keeps the
	// losing line on the side where it still wins at the left end.
	assign left_w    = e_q[0] > e_q[1];
	assign mid_w     = e_q[2] > e_q[3];
	assign go_left_q = 32'(first_q) < 32'(tm_w);
	assign go_left_i = left_w != mid_w;
	always_comb begin
		if (req_q.req_type == lcmr_pkg::REQ_QUERY) begin
			v_next = go_left_q ? {v_q[NW-1:0], 1'b0} : {v_q[NW-1:0], 1'b1};
		end else begin
			v_next = go_left_i ? {v_q[NW-1:0], 1'b0} : {v_q[NW-1:0], 1'b1};
		end
	end

	// Shared multiply-add operands: a query evaluates the node line at x; an
	// insert evaluates new and node lines at the left end and the midpoint.
	always_comb begin
		if (req_q.req_type == lcmr_pkg::REQ_QUERY) begin
			mul_a = ns_q;
			mul_b = nb_q;
			mul_c = cx_q;
		end else begin
			mul_a = k_q[0] ? ns_q : ls_q;
			mul_b = k_q[0] ? nb_q : lb_q;
			mul_c = k_q[1] ? ctm_q : ctl_q;
		end
	end

	// Count writes saturate into the supported range.
	always_comb begin
		cfg_sat = 32'(cfg_data);
		if (cfg_sat < 32'd2) begin
			cfg_sat = 32'd2;
		end else if (cfg_sat > 32'(MAX_COORDS)) begin
			cfg_sat = 32'(MAX_COORDS);
		end
		cfg_cnt = cfg_sat[CNTW-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lcmr_pkg::ST_CLEAR: begin
				if (clr_q == NW'(TREE_NODES - 1)) begin
					state_d = lcmr_pkg::ST_IDLE;
				end
			end
			lcmr_pkg::ST_IDLE: begin
				if (req_fire) begin
					case (req.req_type)
						lcmr_pkg::REQ_LOAD:     state_d = lcmr_pkg::ST_RESP;
						lcmr_pkg::REQ_INSERT:   state_d = undo_full ? lcmr_pkg::ST_RESP
						                                            : lcmr_pkg::ST_I_RD;
						lcmr_pkg::REQ_QUERY:    state_d = lcmr_pkg::ST_LB_RD;
						default:                state_d = lcmr_pkg::ST_RB_RD;
					endcase
				end
			end
			lcmr_pkg::ST_LB_RD: begin
				if (len_q != '0) begin
					state_d = lcmr_pkg::ST_LB_CMP;
				end else if (first_q >= count_q) begin
					state_d = lcmr_pkg::ST_RESP;
				end else begin
					state_d = lcmr_pkg::ST_QC_RD;
				end
			end
			lcmr_pkg::ST_LB_CMP: state_d = lcmr_pkg::ST_LB_RD;
			lcmr_pkg::ST_QC_RD:  state_d = lcmr_pkg::ST_QC_CAP;
			lcmr_pkg::ST_QC_CAP: state_d = lcmr_pkg::ST_Q_RD;
			lcmr_pkg::ST_Q_RD:   state_d = lcmr_pkg::ST_Q_CAP;
			lcmr_pkg::ST_Q_CAP:  state_d = lcmr_pkg::ST_MUL;
			lcmr_pkg::ST_I_RD:   state_d = lcmr_pkg::ST_I_CAP;
			lcmr_pkg::ST_I_CAP:  state_d = lcmr_pkg::ST_I_TM;
			lcmr_pkg::ST_I_TM:   state_d = lcmr_pkg::ST_MUL;
			lcmr_pkg::ST_MUL:    state_d = lcmr_pkg::ST_ADD;
			lcmr_pkg::ST_ADD: begin
				if (req_q.req_type == lcmr_pkg::REQ_QUERY) begin
					state_d = lcmr_pkg::ST_Q_UPD;
				end else if (k_q == 2'd3) begin
					state_d = lcmr_pkg::ST_I_UPD;
				end else begin
					state_d = lcmr_pkg::ST_MUL;
				end
			end
			lcmr_pkg::ST_Q_UPD: begin
				if (last_lvl || 32'(v_next) >= 32'(TREE_NODES)) begin
					state_d = lcmr_pkg::ST_RESP;
				end else begin
					state_d = lcmr_pkg::ST_Q_RD;
				end
			end
			lcmr_pkg::ST_I_UPD: begin
				if (last_lvl || 32'(v_next) >= 32'(TREE_NODES)) begin
					state_d = lcmr_pkg::ST_RESP;
				end else begin
					state_d = lcmr_pkg::ST_I_RD;
				end
			end
			lcmr_pkg::ST_RB_RD: begin
				state_d = (top_q == '0) ? lcmr_pkg::ST_RESP : lcmr_pkg::ST_RB_CHK;
			end
			lcmr_pkg::ST_RB_CHK: begin
				state_d = (uver_rd >= req_q.version) ? lcmr_pkg::ST_RB_RD
				                                     : lcmr_pkg::ST_RESP;
			end
			lcmr_pkg::ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = lcmr_pkg::ST_IDLE;
				end
			end
			default: state_d = lcmr_pkg::ST_IDLE;
		endcase
	end

	// Memory ports and handshake outputs.
	always_comb begin
		req_ready = (state_q == lcmr_pkg::ST_IDLE);
		coord_we  = 1'b0;
		coord_wa  = idx32[CW-1:0];
		coord_ra  = lb_addr[CW-1:0];
		node_we   = 1'b0;
		node_wa   = v_q[NW-1:0];
		node_ws   = ls_q;
		node_wb   = lb_q;
		node_ra   = v_q[NW-1:0];
		undo_we   = 1'b0;
		undo_wa   = top_q[UW-1:0];
		undo_ra   = UW'(top_q - (UW+1)'(1));
		case (state_q)
			lcmr_pkg::ST_CLEAR: begin
				node_we = 1'b1;
				node_wa = clr_q;
				node_ws = '0;
				node_wb = lcmr_pkg::NEG_MARK;
			end
			lcmr_pkg::ST_IDLE: begin
				coord_we = req_fire && (req.req_type == lcmr_pkg::REQ_LOAD) &&
				           (idx32 < 32'(MAX_COORDS));
			end
			lcmr_pkg::ST_QC_RD: coord_ra = first_q[CW-1:0];
			lcmr_pkg::ST_I_RD:  coord_ra = tl_q[CW-1:0];
			lcmr_pkg::ST_I_CAP: coord_ra = tm_w[CW-1:0];
			lcmr_pkg::ST_I_UPD: begin
				node_we = mid_w;
				undo_we = mid_w && (32'(top_q) < 32'(UNDO_DEPTH));
			end
			lcmr_pkg::ST_RB_CHK: begin
				node_we = uver_rd >= req_q.version;
				node_wa = unode_rd;
				node_ws = uslope_rd;
				node_wb = uint_rd;
			end
			default: begin
			end
		endcase
	end

	// Coordinate table.
	always_ff @(posedge clk) begin
		if (coord_we) begin
			coord_mem[coord_wa] <= req.coord_value;
		end
		coord_rd <= coord_mem[coord_ra];
	end

	// Node store: slope and intercept of the line kept at each node.
	always_ff @(posedge clk) begin
		if (node_we) begin
			nslope_mem[node_wa] <= node_ws;
			nint_mem[node_wa]   <= node_wb;
		end
		nslope_rd <= nslope_mem[node_ra];
		nint_rd   <= nint_mem[node_ra];
	end

	// Undo stack: the line a node held before each replacement.
	always_ff @(posedge clk) begin
		if (undo_we) begin
			unode_mem[undo_wa]  <= v_q[NW-1:0];
			uver_mem[undo_wa]   <= req_q.version;
			uslope_mem[undo_wa] <= ns_q;
			uint_mem[undo_wa]   <= nb_q;
		end
		unode_rd  <= unode_mem[undo_ra];
		uver_rd   <= uver_mem[undo_ra];
		uslope_rd <= uslope_mem[undo_ra];
		uint_rd   <= uint_mem[undo_ra];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcmr_pkg::ST_CLEAR;
			clr_q       <= '0;
			top_q       <= '0;
			count_q     <= CNTW'(CNT_RST);
			levels_q    <= LEVELS_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lcmr_pkg::ST_CLEAR) begin
				clr_q <= clr_q + NW'(1);
			end
			if (cfg_fire) begin
				count_q  <= cfg_cnt;
				levels_q <= path_levels(32'(cfg_cnt));
			end
			if (node_we && state_q == lcmr_pkg::ST_I_UPD &&
			    32'(top_q) < 32'(UNDO_DEPTH)) begin
				top_q <= top_q + (UW+1)'(1);
			end else if (node_we && state_q == lcmr_pkg::ST_RB_CHK) begin
				top_q <= top_q - (UW+1)'(1);
			end
			if (state_q == lcmr_pkg::ST_RESP && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			lcmr_pkg::ST_IDLE: begin
				req_q   <= req;
				sts_q   <= (req.req_type == lcmr_pkg::REQ_INSERT && undo_full) ?
				           lcmr_pkg::STS_FULL : lcmr_pkg::STS_OK;
				m_q     <= lcmr_pkg::NEG_MARK;
				first_q <= '0;
				len_q   <= count_q;
				v_q     <= (NW+1)'(1);
				tl_q    <= '0;
				tr_q    <= n_w;
				ls_q    <= req.slope;
				lb_q    <= 64'(req.intercept);
			end
			lcmr_pkg::ST_LB_RD: begin
				if (len_q == '0 && first_q >= count_q) begin
					sts_q <= lcmr_pkg::STS_BEYOND;
				end
			end
			lcmr_pkg::ST_LB_CMP: begin
				if (coord_rd < req_q.coord_value) begin
					first_q <= lb_addr + CNTW'(1);
					len_q   <= len_q - half - CNTW'(1);
				end else begin
					len_q <= half;
				end
			end
			lcmr_pkg::ST_QC_CAP: cx_q <= coord_rd;
			lcmr_pkg::ST_Q_CAP: begin
				ns_q <= nslope_rd;
				nb_q <= nint_rd;
				k_q  <= 2'd0;
			end
			lcmr_pkg::ST_I_CAP: begin
				ns_q  <= nslope_rd;
				nb_q  <= nint_rd;
				ctl_q <= coord_rd;
				k_q   <= 2'd0;
			end
			lcmr_pkg::ST_I_TM: ctm_q <= coord_rd;
			lcmr_pkg::ST_MUL:  p_q <= 64'(mul_a) * 64'(mul_c);
			lcmr_pkg::ST_ADD: begin
				e_q[k_q] <= p_q + mul_b;
				k_q      <= k_q + 2'd1;
			end
			lcmr_pkg::ST_Q_UPD: begin
				if (e_q[0] > m_q) begin
					m_q <= e_q[0];
				end
				v_q <= v_next;
				if (go_left_q) begin
					tr_q <= tm_w;
				end else begin
					tl_q <= tm_w;
				end
			end
			lcmr_pkg::ST_I_UPD: begin
				// The displaced line moves on down the tree.
				if (mid_w) begin
					ls_q <= ns_q;
					lb_q <= nb_q;
				end
				v_q <= v_next;
				if (go_left_i) begin
					tr_q <= tm_w;
				end else begin
					tl_q <= tm_w;
				end
			end
			default: begin
			end
		endcase
	end

	// Response register: a query that found only empty nodes reports empty.
	always_ff @(posedge clk) begin
		if (state_q == lcmr_pkg::ST_RESP && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.status     <= sts_q;
			rsp_q.best_value <= '0;
			if (req_q.req_type == lcmr_pkg::REQ_QUERY && sts_q == lcmr_pkg::STS_OK) begin
				if (m_q == lcmr_pkg::NEG_MARK) begin
					rsp_q.status <= lcmr_pkg::STS_EMPTY;
				end else begin
					rsp_q.best_value <= m_q;
				end
			end
		end
	end

endmodule

@@ rtl/core/lcmr_checker.sv @@
//------------------------------------------------------------------------------
// lcmr_checker: port-level checks of the Li Chao max tree
// Watches the request, response and configuration ports over time.
//------------------------------------------------------------------------------
module lcmr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input lcmr_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input lcmr_pkg::rsp_t rsp,
	input logic           cfg_valid,
	input logic           cfg_ready,
	input logic [10:0]    cfg_data
);

	// A stalled response holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// An accepted request keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// Only a successful query carries a value.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != lcmr_pkg::STS_OK |-> rsp.best_value == '0)
		else $error("value on a failed response");

	// Just after an acceptance no response handshake meets a ready request
	// port: an accepted request leaves the block busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !(rsp_valid && rsp_ready && req_ready))
		else $error("response and new request in the cycle after acceptance");

endmodule

bind li_chao_max_rollback lcmr_checker u_lcmr_checker (.*);

@@ test/li_chao_max_rollback_test.sv @@
//------------------------------------------------------------------------------
// li_chao_max_rollback_test: self-checking bench for the Li Chao max tree
// Drives load, insert, query and rollback requests with random idle gaps on
// both channels, predicts every response with a local model of the tree and
// its undo stack, and compares each response field by field in order.
//------------------------------------------------------------------------------
module li_chao_max_rollback_test;
	import lcmr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_C = 1024;
	localparam int NODES = 4096;
	localparam int UNDO  = 4096;
	localparam longint EMPTY_MARK = -64'sd5000000000000000000;
	localparam int CYCLE_LIMIT = 4000000;
	// Time for the sequencer to settle before a count update.
	localparam int SETTLE = 40;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] cfg_data;

	li_chao_max_rollback DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Local copy of the tree state, kept in step with accepted requests.
	longint      coord_tab [MAX_C];
	longint      node_s    [NODES];
	longint      node_b    [NODES];
	int unsigned undo_node [UNDO];
	int unsigned undo_ver  [UNDO];
	longint      undo_s    [UNDO];
	longint      undo_b    [UNDO];
	int unsigned undo_sp;
	int unsigned cur_count;

	rsp_t        expected_rsp [$];
	int          errors;
	int unsigned cycles;
	int unsigned ver_seq;
	// When set, both sides run without idle gaps.
	bit          no_idle;

	// A row of the directed part; typed rows carry the response to expect.
	typedef struct {
		req_kind_t   kind;
		bit [9:0]    idx;
		int          val;
		int          slp;
		int          icpt;
		int unsigned ver;
		bit          typed;
		status_t     st;
		longint      best;
	} plan_row_t;

	plan_row_t plan [24];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("li_chao_max_rollback verification failed");
			$finish;
		end
	end

	function automatic int unsigned path_depth(int unsigned span);
		int unsigned d;
		d = 1;
		while (span > 1) begin
			span = (span + 1) >> 1;
			d++;
		end
		return d;
	endfunction

	function automatic longint line_val(longint s, longint b, int unsigned idx);
		longint c;
		c = (idx < MAX_C) ? coord_tab[idx] : 64'sd0;
		return s * c + b;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Applies one request to the local tree and returns the response it causes.
	function automatic rsp_t tree_step(req_t r);
		rsp_t        o;
		int unsigned n, v, tl, tr, tm, first, len, half, x;
		longint      ls, lb, ts, tb, m, e, xv;
		bit          lft, md;
		o.status = STS_OK;
		o.best_value = 64'sd0;
		n = cur_count - 1;
		case (r.req_type)
			REQ_LOAD: begin
				coord_tab[r.coord_index] = $signed(r.coord_value);
			end
			REQ_INSERT: begin
				if (UNDO - undo_sp < path_depth(n)) begin
					o.status = STS_FULL;
				end else begin
					ls = $signed(r.slope);
					lb = $signed(r.intercept);
					v = 1;
					tl = 0;
					tr = n;
					while (v < NODES) begin
						tm = (tl + tr) >> 1;
						lft = line_val(ls, lb, tl) > line_val(node_s[v], node_b[v], tl);
						md = line_val(ls, lb, tm) > line_val(node_s[v], node_b[v], tm);
						if (md) begin
							ts = node_s[v];
							tb = node_b[v];
							if (undo_sp < UNDO) begin
								undo_node[undo_sp] = v;
								undo_ver[undo_sp] = r.version;
								undo_s[undo_sp] = ts;
								undo_b[undo_sp] = tb;
								undo_sp++;
							end
							node_s[v] = ls;
							node_b[v] = lb;
							ls = ts;
							lb = tb;
						end
						if (tl + 1 >= tr)
							break;
						if (lft != md) begin
							v = v << 1;
							tr = tm;
						end else begin
							v = (v << 1) | 1;
							tl = tm;
						end
					end
				end
			end
			REQ_QUERY: begin
				// Lower-bound search by halving, exactly as the block does it.
				xv = $signed(r.coord_value);
				first = 0;
				len = cur_count;
				while (len > 0) begin
					half = len >> 1;
					if (coord_tab[first + half] < xv) begin
						first += half + 1;
						len -= half + 1;
					end else begin
						len = half;
					end
				end
				x = first;
				if (x >= cur_count) begin
					o.status = STS_BEYOND;
				end else begin
					v = 1;
					tl = 0;
					tr = n;
					m = EMPTY_MARK;
					while (v < NODES) begin
						e = line_val(node_s[v], node_b[v], x);
						if (e > m)
							m = e;
						if (tl + 1 >= tr)
							break;
						tm = (tl + tr) >> 1;
						if (x < tm) begin
							v = v << 1;
							tr = tm;
						end else begin
							v = (v << 1) | 1;
							tl = tm;
						end
					end
					if (m == EMPTY_MARK)
						o.status = STS_EMPTY;
					else
						o.best_value = m;
				end
			end
			default: begin
				while (undo_sp > 0 && undo_ver[undo_sp - 1] >= r.version) begin
					undo_sp--;
					v = undo_node[undo_sp];
					if (v < NODES) begin
						node_s[v] = undo_s[undo_sp];
						node_b[v] = undo_b[undo_sp];
					end
				end
			end
		endcase
		return o;
	endfunction

	// Presents one request, holds it until it is taken, and files its response.
	// A typed response, when given, replaces the predicted one in the queue.
	task automatic send(req_t r, bit typed = 1'b0, rsp_t want = '0);
		int unsigned g;
		rsp_t        p;
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		p = tree_step(r);
		expected_rsp.push_back(typed ? want : p);
	endtask

	// Count updates happen only with the block idle: no response outstanding.
	task automatic write_count(logic [10:0] val);
		int unsigned c;
		req_valid <= 1'b0;
		while (expected_rsp.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		c = val;
		if (c < 2)
			c = 2;
		if (c > MAX_C)
			c = MAX_C;
		cur_count <= c;
		cur_count = c;
	endtask

	function automatic req_t make_req(req_kind_t k, int unsigned idx, int val, int slp,
			int icpt, int unsigned ver);
		req_t r;
		r.req_type = k;
		r.coord_index = idx[9:0];
		r.coord_value = val;
		r.slope = slp;
		r.intercept = icpt;
		r.version = ver;
		return r;
	endfunction

	// Loads every slot the current count can reach, sorted, either across the
	// whole 32-bit range or packed tightly with repeated values.
	task automatic fill_table(bit wide);
		longint      stp, base, vv;
		int unsigned k;
		stp = 64'sd4294967295 / cur_count;
		base = -64'sd2147483648;
		for (k = 0; k < cur_count; k++) begin
			if (wide)
				vv = base + k * stp + $urandom_range(0, int'(stp) - 1);
			else
				vv = -64'sd100 + (k / 2) * 3;
			send(make_req(REQ_LOAD, k, int'(vv), $urandom, $urandom, $urandom));
		end
	endtask

	function automatic int pick_x();
		int unsigned r;
		int          t;
		r = $urandom_range(0, 9);
		t = int'(coord_tab[$urandom_range(0, cur_count - 1)]);
		case (r)
			0, 1, 2: return t;
			3: return t + 1;
			4: return t - 1;
			5: return $urandom;
			6: return 32'sh7fffffff;
			7: return 32'sh80000000;
			default: return $urandom_range(0, 400) - 200;
		endcase
	endfunction

	function automatic int pick_coef();
		if ($urandom_range(0, 2) == 0)
			return $urandom;
		return $urandom_range(0, 2000) - 1000;
	endfunction

	// Random traffic with all four request kinds; loads may unsort the table.
	task automatic mix(int unsigned count_items);
		int unsigned i, r, tgt;
		for (i = 0; i < count_items; i++) begin
			if (i % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 40) begin
				send(make_req(REQ_QUERY, $urandom, pick_x(), $urandom, $urandom, $urandom));
			end else if (r < 75) begin
				ver_seq += $urandom_range(0, 2);
				send(make_req(REQ_INSERT, $urandom, $urandom, pick_coef(), pick_coef(),
					($urandom_range(0, 19) == 0) ? $urandom : ver_seq));
			end else if (r < 85) begin
				tgt = ($urandom_range(0, 9) == 0) ? $urandom : ver_seq - $urandom_range(0, 20);
				send(make_req(REQ_ROLLBACK, $urandom, $urandom, $urandom, $urandom, tgt));
			end else if (r < 95) begin
				send(make_req(REQ_LOAD, $urandom_range(0, MAX_C - 1), pick_x(),
					$urandom, $urandom, $urandom));
			end else begin
				// Hold off until the block has drained completely.
				req_valid <= 1'b0;
				while (expected_rsp.size() > 0) @(posedge clk);
				send(make_req(REQ_QUERY, $urandom, pick_x(), $urandom, $urandom, $urandom));
			end
		end
		no_idle = 1'b0;
	endtask

	// Response side: random back-pressure and in-order comparison.
	int unsigned stall;
	always @(posedge clk) begin
		rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				$error("response with no request pending: status %0d value %0d",
					rsp.status, rsp.best_value);
				errors++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.best_value !== want.best_value) begin
					$error("best_value: expected %0d, actual %0d",
						want.best_value, rsp.best_value);
					errors++;
				end
			end
		end
		if (stall > 0) begin
			stall <= stall - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
			stall <= gap_len();
		end
	end

	initial begin
		int   i;
		rsp_t want;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		stall = 0;
		ver_seq = 10;
		no_idle = 1'b0;
		foreach (coord_tab[k])
			coord_tab[k] = 0;
		foreach (node_s[k]) begin
			node_s[k] = 0;
			node_b[k] = EMPTY_MARK;
		end
		undo_sp = 0;
		cur_count = MAX_C;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// A zero count saturates up to the smallest tree of two coordinates.
		write_count(11'd0);

		// Directed part on the two-coordinate tree: empty set, beyond the
		// table, extreme slopes and intercepts, rollbacks that undo part and
		// all of the history, and a load into a slot past the count.
		plan = '{
			'{REQ_LOAD,     10'd0,    -1000,          0,           0,           0,
				1'b1, STS_OK,     0},
			'{REQ_LOAD,     10'd1,    1000,           0,           0,           0,
				1'b1, STS_OK,     0},
			'{REQ_QUERY,    10'd0,    0,              0,           0,           0,
				1'b1, STS_EMPTY,  0},
			'{REQ_QUERY,    10'd0,    1001,           0,           0,           0,
				1'b1, STS_BEYOND, 0},
			'{REQ_QUERY,    10'd0,    32'sh80000000,  0,           0,           0,
				1'b1, STS_EMPTY,  0},
			'{REQ_INSERT,   10'd0,    0,              3,           5,           1,
				1'b1, STS_OK,     0},
			'{REQ_QUERY,    10'd0,    -1000,          0,           0,           0,
				1'b1, STS_OK,     -2995},
			'{REQ_QUERY,    10'd0,    500,            0,           0,           0,
				1'b0, STS_OK,     0},
			'{REQ_INSERT,   10'd0,    0,              32'sh80000000, 32'sh7fffffff, 2,
				1'b0, STS_OK,     0},
			'{REQ_QUERY,    10'd0,    -1000,          0,           0,           0,
				1'b0, STS_OK,     0},
			'{REQ_INSERT,   10'd0,    0,              32'sh7fffffff, 32'sh80000000, 3,
				1'b0, STS_OK,     0},
			'{REQ_QUERY,    10'd0,    1000,           0,           0,           0,
				1'b0, STS_OK,     0},
			'{REQ_ROLLBACK, 10'd0,    0,              0,           0,           3,
				1'b1, STS_OK,     0},
			'{REQ_QUERY,    10'd0,    1000,           0,           0,           0,
				1'b0, STS_OK,     0},
			'{REQ_ROLLBACK, 10'd0,    0,              0,           0,           0,
				1'b1, STS_OK,     0},
			'{REQ_QUERY,    10'd0,    0,              0,           0,           0,
				1'b1, STS_EMPTY,  0},
			'{REQ_LOAD,     10'd1023, 32'sh7fffffff,  0,           0,           0,
				1'b1, STS_OK,     0},
			'{REQ_LOAD,     10'd1,    32'sh7fffffff,  0,           0,           0,
				1'b1, STS_OK,     0},
			'{REQ_LOAD,     10'd0,    32'sh80000000,  0,           0,           0,
				1'b1, STS_OK,     0},
			'{REQ_INSERT,   10'd0,    0,              32'sh7fffffff, 32'sh7fffffff,
				32'hffffffff, 1'b0, STS_OK, 0},
			'{REQ_QUERY,    10'd0,    32'sh7fffffff,  0,           0,           0,
				1'b0, STS_OK,     0},
			'{REQ_QUERY,    10'd0,    -2147483647,    0,           0,           0,
				1'b0, STS_OK,     0},
			'{REQ_ROLLBACK, 10'd0,    0,              0,           0,           32'hffffffff,
				1'b1, STS_OK,     0},
			'{REQ_QUERY,    10'd0,    5,              0,           0,           0,
				1'b1, STS_EMPTY,  0}
		};
		foreach (plan[k]) begin
			want.status = plan[k].st;
			want.best_value = plan[k].best;
			send(make_req(plan[k].kind, plan[k].idx, plan[k].val, plan[k].slp,
				plan[k].icpt, plan[k].ver), plan[k].typed, want);
		end
		mix(60);

		// A small tree with a tightly packed table full of repeats.
		write_count(11'($urandom_range(3, 40)));
		fill_table(1'b0);
		mix(250);

		// The widest setting reached through saturation of an over-range value.
		write_count(11'h7ff);
		fill_table(1'b1);
		mix(200);

		// Fill the undo stack with dominating flat lines until inserts are
		// refused, then roll part of the history back and keep going.
		write_count(11'd256);
		fill_table(1'b1);
		send(make_req(REQ_ROLLBACK, 0, 0, 0, 0, 0));
		for (i = 0; i < 500; i++)
			send(make_req(REQ_INSERT, $urandom, $urandom, 0, i * 1000, 1000 + i));
		send(make_req(REQ_QUERY, 0, pick_x(), 0, 0, 0));
		send(make_req(REQ_ROLLBACK, 0, 0, 0, 0, 1200));
		ver_seq = 1300;
		mix(150);

		// A few more random tree sizes, the exact upper extreme among them.
		write_count(11'd1024);
		fill_table(1'b1);
		mix(150);
		write_count(11'($urandom_range(2, 100)));
		fill_table($urandom_range(0, 1));
		mix(200);
		write_count(11'd2);
		fill_table(1'b1);
		mix(60);

		req_valid <= 1'b0;
		while (expected_rsp.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("li_chao_max_rollback verification clean");
		else
			$display("li_chao_max_rollback verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/lcmr_pkg.sv
rtl/core/li_chao_max_rollback.sv
rtl/core/lcmr_checker.sv
test/li_chao_max_rollback_test.sv
